[rtl/lbca_pkg.sv]
package lbca_pkg;

   // table geometry
   localparam int BLOCKS = 256;
   localparam int IDX_W  = 8;
   localparam int CNT_W  = 9;
   localparam logic [CNT_W-1:0] BLOCKS_CNT = CNT_W'(BLOCKS);

   // entry kinds
   localparam logic [1:0] KIND_FREE = 2'd0;
   localparam logic [1:0] KIND_BAD  = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;
   localparam logic [1:0] KIND_LINK = 2'd3;

   // operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_MARK    = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NOT_ENOUGH  = 3'd1;
   localparam logic [2:0] ST_ZERO_COUNT  = 3'd2;
   localparam logic [2:0] ST_BAD_RELEASE = 3'd3;
   localparam logic [2:0] ST_MARK_REFUSE = 3'd4;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] next;
   } entry_type;

   localparam entry_type FREE_ENTRY = '{kind: KIND_FREE, next: '0};

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } tbl_req_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [CNT_W-1:0] block_count;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] first_block;
      logic [CNT_W-1:0] blocks_freed;
      logic [CNT_W-1:0] free_blocks;
   } rsp_type;

endpackage

[rtl/linked_block_chain_allocator.sv]
// channel    ports                        direction  handshake
// request    start, busy, req_data        in         taken when start & !busy
// response   rsp_valid, rsp_data          out        one-cycle strobe, no stall
// csr        csr_we, csr_wdata            in         written when csr_we
//
// allocate scans the table one entry per cycle
// release walks the chain one block per cycle, until the end entry or a broken link
// mark bad reads the entry through the single table read port, then marks it if free
// a csr write while idle or counting recounts used blocks, busy meanwhile
// reset clears the table through per-entry valid bits
// the receiver cannot stall responses
module linked_block_chain_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lbca_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output lbca_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [lbca_pkg::CNT_W-1:0]   csr_wdata
);
   import lbca_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COUNT = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_AEND  = 3'd3;
   localparam logic [2:0] S_REL   = 3'd4;
   localparam logic [2:0] S_MARK  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] disk_ff, disk_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0] got_ff, got_in;
   logic [CNT_W-1:0] want_ff, want_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] freed_ff, freed_in;
   logic [2:0]       status_ff, status_in;

   logic [CNT_W-1:0] size;
   logic [CNT_W-1:0] avail;
   tbl_req_type      tbl_req;
   entry_type        rd_data;

   lbca_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   // usable size and free count
   assign size  = (disk_ff > BLOCKS_CNT) ? BLOCKS_CNT : disk_ff;
   assign avail = size - taken_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      disk_in      = disk_ff;
      taken_in     = taken_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      got_in       = got_ff;
      want_in      = want_ff;
      prev_in      = prev_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      freed_in     = freed_ff;
      status_in    = status_ff;
      tbl_req      = '0;

      if (csr_we) begin
         disk_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               state_in = S_COUNT;
               scan_in  = '0;
               pend_in  = 1'b0;
               got_in   = '0;
            end else if (start) begin
               head_in   = '0;
               freed_in  = '0;
               status_in = ST_OK;
               unique case (req_data.operation)
                  OP_ALLOC: begin
                     want_in = req_data.block_count;
                     got_in  = '0;
                     scan_in = '0;
                     pend_in = 1'b0;
                     priority if (req_data.block_count == '0) begin
                        status_in = ST_ZERO_COUNT;
                        state_in  = S_DONE;
                     end else if (req_data.block_count > avail) begin
                        status_in = ST_NOT_ENOUGH;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_RELEASE: begin
                     tbl_req.rd_en   = 1'b1;
                     tbl_req.rd_addr = req_data.block_index;
                     cur_in          = req_data.block_index;
                     first_in        = 1'b1;
                     state_in        = S_REL;
                  end
                  OP_MARK: begin
                     if ({1'b0, req_data.block_index} >= size) begin
                        status_in = ST_MARK_REFUSE;
                        state_in  = S_DONE;
                     end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = req_data.block_index;
                        cur_in          = req_data.block_index;
                        state_in        = S_MARK;
                     end
                  end
                  default: begin
                     status_in = ST_MARK_REFUSE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // recount used blocks below the usable size
         S_COUNT: begin
            if (csr_we) begin
               scan_in = '0;
               pend_in = 1'b0;
               got_in  = '0;
            end else begin
               if (scan_ff < size) begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = scan_ff[IDX_W-1:0];
                  scan_in         = scan_ff + 1'b1;
                  pend_in         = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
               if (pend_ff && rd_data.kind != KIND_FREE) begin
                  got_in = got_ff + 1'b1;
               end
               if (scan_ff >= size && !pend_ff) begin
                  taken_in = got_ff;
                  state_in = S_IDLE;
               end
            end
         end

         // scan ascending, link each free block from the previous one
         S_ALLOC: begin
            if (scan_ff < size) begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = scan_ff[IDX_W-1:0];
               scan_in         = scan_ff + 1'b1;
               pend_in         = 1'b1;
               pend_addr_in    = scan_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && rd_data.kind == KIND_FREE) begin
               if (got_ff == '0) begin
                  head_in = pend_addr_ff;
               end else begin
                  tbl_req.wr_en        = 1'b1;
                  tbl_req.wr_addr      = prev_ff;
                  tbl_req.wr_data.kind = KIND_LINK;
                  tbl_req.wr_data.next = pend_addr_ff;
               end
               prev_in = pend_addr_ff;
               got_in  = got_ff + 1'b1;
               if (got_ff + 1'b1 == want_ff) begin
                  state_in = S_AEND;
               end
            end
         end

         // close the chain
         S_AEND: begin
            tbl_req.wr_en        = 1'b1;
            tbl_req.wr_addr      = prev_ff;
            tbl_req.wr_data.kind = KIND_END;
            tbl_req.wr_data.next = '0;
            taken_in             = taken_ff + want_ff;
            state_in             = S_DONE;
         end

         // walk the chain, freeing one block per cycle
         S_REL: begin
            first_in = 1'b0;
            if (rd_data.kind == KIND_END || rd_data.kind == KIND_LINK) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = cur_ff;
               tbl_req.wr_data = FREE_ENTRY;
               freed_in        = freed_ff + 1'b1;
               if ({1'b0, cur_ff} < size) begin
                  taken_in = taken_ff - 1'b1;
               end
               if (rd_data.kind == KIND_END) begin
                  state_in = S_DONE;
               end else begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = rd_data.next;
                  cur_in          = rd_data.next;
               end
            end else begin
               if (first_ff) begin
                  status_in = ST_BAD_RELEASE;
               end
               state_in = S_DONE;
            end
         end

         S_MARK: begin
            if (rd_data.kind == KIND_FREE) begin
               tbl_req.wr_en        = 1'b1;
               tbl_req.wr_addr      = cur_ff;
               tbl_req.wr_data.kind = KIND_BAD;
               tbl_req.wr_data.next = '0;
               taken_in             = taken_ff + 1'b1;
            end else begin
               status_in = ST_MARK_REFUSE;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         disk_ff  <= BLOCKS_CNT;
         taken_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         disk_ff  <= disk_in;
         taken_ff <= taken_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      got_ff       <= got_in;
      want_ff      <= want_in;
      prev_ff      <= prev_in;
      head_ff      <= head_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      freed_ff     <= freed_in;
      status_ff    <= status_in;
   end

   // response transaction
   assign busy                  = (state_ff != S_IDLE) || csr_we;
   assign rsp_valid             = (state_ff == S_DONE);
   assign rsp_data.status       = status_ff;
   assign rsp_data.first_block  = head_ff;
   assign rsp_data.blocks_freed = freed_ff;
   assign rsp_data.free_blocks  = avail;

endmodule

[rtl/lbca_table.sv]
module lbca_table (
   input  logic                 clock,
   input  logic                 reset,
   input  lbca_pkg::tbl_req_type tbl_req,
   output lbca_pkg::entry_type  rd_data
);
   import lbca_pkg::*;

   logic [BLOCKS-1:0] valid_ff;
   entry_type         mem_ff [BLOCKS];
   entry_type         rd_mem_ff;
   logic              rd_valid_ff;

   // per-entry valid bits, cleared at reset so the table reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_req.wr_en) begin
         valid_ff[tbl_req.wr_addr] <= 1'b1;
      end
   end

   // storage with registered read, read-first
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem_ff[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_mem_ff   <= mem_ff[tbl_req.rd_addr];
         rd_valid_ff <= valid_ff[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : FREE_ENTRY;

endmodule

[rtl/lbca_checker.sv]
module lbca_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input lbca_pkg::req_type          req_data,
   input logic                       rsp_valid,
   input lbca_pkg::rsp_type          rsp_data,
   input logic                       csr_we,
   input logic [lbca_pkg::CNT_W-1:0] csr_wdata
);
   import lbca_pkg::*;

   // an accepted transaction keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // a response is a single-cycle strobe followed by idle
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && (!busy || csr_we)))
      else $error("response strobe longer than one cycle");

   // refused transactions carry no head and no freed count
   a_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.first_block == '0 && rsp_data.blocks_freed == '0))
      else $error("refused transaction reports head or freed blocks");

   // free count and freed count never exceed the table size
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.free_blocks <= BLOCKS_CNT &&
                     rsp_data.blocks_freed <= BLOCKS_CNT))
      else $error("block count out of range");

endmodule

bind linked_block_chain_allocator lbca_checker u_lbca_checker (.*);
